### hw/rtl/websocket_frame_deframer_unit_defines.svh
// assertion macros for the websocket deframer
`ifndef WEBSOCKET_FRAME_DEFRAMER_UNIT_DEFINES_SVH
`define WEBSOCKET_FRAME_DEFRAMER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// condition holds at every edge outside reset
`define WSD_ASSERT(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
// antecedent implies consequent in the same cycle
`define WSD_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define WSD_ASSERT(lbl, clk, rst, cond, msg)
`define WSD_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`endif

`endif

### hw/rtl/wsd_pkg.sv
package wsd_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  localparam logic [3:0] OP_CLOSE = 4'h8;
  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;
  localparam logic [2:0] EXT16_BYTES = 3'd2;
  localparam logic [2:0] EXT64_BYTES = 3'd0;  // eight bytes, counted modulo 8

  typedef enum logic [2:0] {
    PH_HDR0 = 3'd0,
    PH_HDR1 = 3'd1,
    PH_EXT  = 3'd2,
    PH_MASK = 3'd3,
    PH_DATA = 3'd4
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       restart;
  } in_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic [3:0] frame_opcode;
    logic       frame_last;
    logic       frame_empty;
    logic       closing;
  } res_t;

  // classified byte handed from parser to output side
  typedef struct packed {
    logic [7:0] data;
    logic [7:0] key_byte;
    logic       masked;
    logic [3:0] opcode;
    logic       last;
    logic       empty;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic has_data;
  } qstat_t;

endpackage

### hw/rtl/wsd_front.sv
module wsd_front
  import wsd_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic accept,
  input  in_t  item,
  output logic emit,
  output cmd_t cmd
);

  phase_t          phase, phase_next, cur_phase;
  logic            closed, closed_next, cur_closed;
  logic [3:0]      opcode, opcode_next;
  logic            masked, masked_next;
  logic [2:0]      ext_count, ext_count_next;
  logic [63:0]     length, length_next;
  logic [63:0]     remaining, remaining_next;
  logic [3:0][7:0] key, key_next;
  logic [1:0]      key_idx, key_idx_next;

  logic            len_done;
  logic            pay_start;
  logic [63:0]     len_val;
  logic [7:0]      b;

  assign b = item.data_byte;
  // restart drops back to header start before the byte is parsed
  assign cur_phase  = item.restart ? PH_HDR0 : phase;
  assign cur_closed = item.restart ? 1'b0 : closed;

  always_comb begin
    phase_next     = cur_phase;
    closed_next    = cur_closed;
    opcode_next    = opcode;
    masked_next    = masked;
    ext_count_next = ext_count;
    length_next    = length;
    remaining_next = remaining;
    key_next       = key;
    key_idx_next   = key_idx;
    len_done       = 1'b0;
    pay_start      = 1'b0;
    len_val        = length;
    emit           = 1'b0;
    cmd.data       = b;
    cmd.key_byte   = key[~key_idx];
    cmd.masked     = masked;
    cmd.opcode     = opcode;
    cmd.last       = 1'b0;
    cmd.empty      = 1'b0;

    if (!cur_closed) begin
      case (cur_phase)
        PH_HDR1: begin
          masked_next = b[7];
          length_next = 64'd0;
          if (b[6:0] == LEN_EXT16) begin
            ext_count_next = EXT16_BYTES;
            phase_next     = PH_EXT;
          end else if (b[6:0] == LEN_EXT64) begin
            ext_count_next = EXT64_BYTES;
            phase_next     = PH_EXT;
          end else begin
            length_next = {57'd0, b[6:0]};
            len_val     = {57'd0, b[6:0]};
            len_done    = 1'b1;
          end
        end
        PH_EXT: begin
          length_next    = {length[55:0], b};
          len_val        = {length[55:0], b};
          ext_count_next = ext_count - 3'd1;
          len_done       = (ext_count_next == 3'd0);
        end
        PH_MASK: begin
          key_next = {key[2:0], b};
          if (key_idx != 2'd3) begin
            key_idx_next = key_idx + 2'd1;
          end else begin
            pay_start = 1'b1;
          end
        end
        PH_DATA: begin
          key_idx_next   = key_idx + 2'd1;
          remaining_next = remaining - 64'd1;
          cmd.last       = (remaining == 64'd1);
          emit           = 1'b1;
          if (cmd.last) begin
            phase_next = PH_HDR0;
          end
        end
        default: begin
          opcode_next = b[3:0];
          phase_next  = PH_HDR1;
        end
      endcase

      // header length complete: mask key next, or straight to payload or an empty-frame result
      if (len_done) begin
        if (masked_next) begin
          key_next     = '0;
          key_idx_next = 2'd0;
          phase_next   = PH_MASK;
        end else begin
          pay_start = 1'b1;
        end
      end

      if (pay_start) begin
        key_idx_next = 2'd0;
        if (len_val == 64'd0) begin
          phase_next = PH_HDR0;
          emit       = 1'b1;
          cmd.data   = 8'd0;
          cmd.last   = 1'b1;
          cmd.empty  = 1'b1;
        end else begin
          remaining_next = len_val;
          phase_next     = PH_DATA;
        end
      end

      if (emit && cmd.last && (opcode == OP_CLOSE)) begin
        closed_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= PH_HDR0;
      closed <= 1'b0;
    end else if (accept) begin
      phase  <= phase_next;
      closed <= closed_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      opcode    <= opcode_next;
      masked    <= masked_next;
      ext_count <= ext_count_next;
      length    <= length_next;
      remaining <= remaining_next;
      key       <= key_next;
      key_idx   <= key_idx_next;
    end
  end

endmodule

### hw/rtl/wsd_queue.sv
module wsd_queue
  import wsd_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   wr,
  input  cmd_t   wr_data,
  input  logic   rd,
  output cmd_t   rd_data,
  output qstat_t stat
);

  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);

  cmd_t              mem [DEPTH];
  logic [ADDR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_wr, do_rd;

  assign stat.full     = (count == CNT_W'(DEPTH));
  assign stat.has_data = (count != '0);
  assign do_wr         = wr && !stat.full;
  assign do_rd         = rd && stat.has_data;
  assign rd_data       = mem[rd_ptr];

  function automatic logic [ADDR_W-1:0] bump(input logic [ADDR_W-1:0] p);
    bump = (p == ADDR_W'(DEPTH - 1)) ? '0 : p + ADDR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (do_rd) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (do_wr && !do_rd) begin
        count <= count + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

### hw/rtl/wsd_back.sv
module wsd_back
  import wsd_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  qstat_t q_stat,
  input  cmd_t   q_data,
  output logic   q_rd,
  input  logic   pop,
  output logic   empty,
  output res_t   result
);

  logic out_valid;
  logic load;
  res_t res_next;

  assign empty = !out_valid;
  assign load  = !out_valid || pop;
  assign q_rd  = load && q_stat.has_data;

  always_comb begin
    res_next.payload_byte = q_data.masked ? (q_data.data ^ q_data.key_byte) : q_data.data;
    if (q_data.empty) begin
      res_next.payload_byte = 8'd0;
    end
    res_next.frame_opcode = q_data.opcode;
    res_next.frame_last   = q_data.last;
    res_next.frame_empty  = q_data.empty;
    res_next.closing      = q_data.last && (q_data.opcode == OP_CLOSE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= q_stat.has_data;
    end
  end

  always_ff @(posedge clk) begin
    if (q_rd) begin
      result <= res_next;
    end
  end

endmodule

### hw/rtl/websocket_frame_deframer_unit.sv
// a result byte passes the queue and then the result register on its way to the result ports
// throughput: one byte per cycle unless full; parser and 64-bit length counter step per byte
// a header byte that yields no result still needs a free queue slot to be taken
// reset: synchronous rst clears the parser phase, closed flag, queue pointers and output valid
// restart on an input byte returns the parser to header start before that byte is taken
module websocket_frame_deframer_unit
  import wsd_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  in_t  item,
  output logic empty,
  input  logic pop,
  output res_t result
);

`include "websocket_frame_deframer_unit_defines.svh"

  // front side: header parse and byte classification
  logic   accept;
  logic   f_emit;
  cmd_t   f_cmd;

  // short queue between parser and output stage
  qstat_t q_stat;
  cmd_t   q_data;
  logic   q_rd;

  // an input transaction is taken only while the queue has a slot,
  // whether or not the byte turns into a result
  assign full   = q_stat.full;
  assign accept = push && !full;

  wsd_front u_front (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (item),
    .emit   (f_emit),
    .cmd    (f_cmd)
  );

  wsd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (accept && f_emit),
    .wr_data (f_cmd),
    .rd      (q_rd),
    .rd_data (q_data),
    .stat    (q_stat)
  );

  // back side: unmask and hold the result until a pop transaction
  wsd_back u_back (
    .clk    (clk),
    .rst    (rst),
    .q_stat (q_stat),
    .q_data (q_data),
    .q_rd   (q_rd),
    .pop    (pop),
    .empty  (empty),
    .result (result)
  );

  // a full queue must hold entries
  `WSD_ASSERT_IMP(a_full_has_data, clk, rst, q_stat.full, q_stat.has_data, "queue full with no data")
  // close results only end a frame
  `WSD_ASSERT_IMP(a_close_is_last, clk, rst, !empty && result.closing, result.frame_last, "closing without last")
  // empty frame results carry a zero byte and end the frame
  `WSD_ASSERT_IMP(a_empty_frame, clk, rst, !empty && result.frame_empty, result.frame_last && (result.payload_byte == 8'd0), "bad empty frame result")
  // output stage never reads an empty queue
  `WSD_ASSERT(a_rd_has_data, clk, rst, !q_rd || q_stat.has_data, "read of empty queue")

endmodule

### tb/sv/deframer_checker.sv
`timescale 1ns / 100ps

module deframer_checker
  import wsd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic        full,
  input  in_t         item,
  input  logic        empty,
  input  logic        pop,
  input  res_t        result,
  output int unsigned mismatches,
  output int unsigned outstanding
);

  // parser state as the block should hold it
  phase_t      phase;
  logic [3:0]  opcode;
  logic        masked;
  logic [2:0]  ext_left;
  logic [63:0] length_sum;
  logic [63:0] payload_left;
  logic [31:0] key;
  logic [1:0]  key_pos;
  logic        closed;

  res_t        expected_payload[$];
  res_t        predicted;
  res_t        oldest;
  int unsigned error_count;

  function automatic void clear_parser();
    phase        = PH_HDR0;
    opcode       = '0;
    masked       = 1'b0;
    ext_left     = '0;
    length_sum   = '0;
    payload_left = '0;
    key          = '0;
    key_pos      = '0;
    closed       = 1'b0;
  endfunction

  function automatic res_t tag_result(input logic [7:0] value, input bit last, input bit none);
    res_t r;
    r.payload_byte = value;
    r.frame_opcode = opcode;
    r.frame_last   = last;
    r.frame_empty  = none;
    r.closing      = last && (opcode == OP_CLOSE);
    if (r.closing) closed = 1'b1;
    return r;
  endfunction

  // header complete: either an empty-frame result now or payload follows
  function automatic bit open_payload(output res_t r);
    key_pos = '0;
    if (length_sum == '0) begin
      phase = PH_HDR0;
      r = tag_result(8'h00, 1'b1, 1'b1);
      return 1'b1;
    end
    payload_left = length_sum;
    phase = PH_DATA;
    return 1'b0;
  endfunction

  function automatic bit length_done(output res_t r);
    if (masked) begin
      key     = '0;
      key_pos = '0;
      phase   = PH_MASK;
      return 1'b0;
    end
    return open_payload(r);
  endfunction

  // one byte of the stream; returns 1 when it yields a result
  function automatic bit deframe_byte(input in_t it, output res_t r);
    logic [7:0] b;
    logic [7:0] v;
    logic [6:0] len7;
    bit         made;
    b = it.data_byte;
    made = 1'b0;
    r = '0;
    if (it.restart) clear_parser();
    if (closed) return 1'b0;
    case (phase)
      PH_HDR1: begin
        masked = b[7];
        len7 = b[6:0];
        length_sum = '0;
        if (len7 == LEN_EXT16) begin
          ext_left = EXT16_BYTES;
          phase = PH_EXT;
        end else if (len7 == LEN_EXT64) begin
          ext_left = EXT64_BYTES;
          phase = PH_EXT;
        end else begin
          length_sum = {57'd0, len7};
          made = length_done(r);
        end
      end
      PH_EXT: begin
        length_sum = {length_sum[55:0], b};
        ext_left = ext_left - 3'd1;
        if (ext_left == '0) made = length_done(r);
      end
      PH_MASK: begin
        key = {key[23:0], b};
        if (key_pos != 2'd3) key_pos = key_pos + 2'd1;
        else made = open_payload(r);
      end
      PH_DATA: begin
        v = b;
        if (masked) v = v ^ key[8 * (3 - key_pos) +: 8];
        key_pos = key_pos + 2'd1;
        payload_left = payload_left - 64'd1;
        if (payload_left == '0) phase = PH_HDR0;
        r = tag_result(v, payload_left == '0, 1'b0);
        made = 1'b1;
      end
      default: begin
        opcode = b[3:0];
        phase = PH_HDR1;
      end
    endcase
    return made;
  endfunction

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      error_count++;
    end
  endtask

  initial begin
    error_count = 0;
    clear_parser();
  end

  always @(posedge clk) begin
    if (rst) begin
      clear_parser();
      expected_payload.delete();
    end else begin
      if (pop && !empty) begin
        if (expected_payload.size() == 0) begin
          $display("%0t: unexpected result expected none actual %p", $time, result);
          error_count++;
        end else begin
          oldest = expected_payload.pop_front();
          check_field("payload_byte", oldest.payload_byte, result.payload_byte);
          check_field("frame_opcode", oldest.frame_opcode, result.frame_opcode);
          check_field("frame_last", oldest.frame_last, result.frame_last);
          check_field("frame_empty", oldest.frame_empty, result.frame_empty);
          check_field("closing", oldest.closing, result.closing);
        end
      end
      if (push && !full) begin
        if (deframe_byte(item, predicted)) expected_payload.push_back(predicted);
      end
    end
    outstanding <= expected_payload.size();
    mismatches  <= error_count;
  end

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import wsd_pkg::*;

  // cycles with no transaction on either side before the run is called hung
  localparam int unsigned STALL_LIMIT = 5000;
  // receiver holds off this long once, so the queue fills and push backs up
  localparam int unsigned LONG_HOLD   = 400;
  localparam int unsigned HOLD_AFTER  = 300;
  localparam int unsigned ITEM_TARGET = 1300;

  // how the payload length is carried in the header
  typedef enum int {
    LEN_SHORT,
    LEN_16,
    LEN_64
  } len_form_t;

  logic clk;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic pop = 1'b0;
  in_t  item = '0;
  logic full;
  logic empty;
  res_t result;

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned bytes_sent = 0;
  int unsigned results_taken = 0;

  logic [7:0] frame_bytes[$];

  websocket_frame_deframer_unit dut (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .item   (item),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

  deframer_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .item        (item),
    .empty       (empty),
    .pop         (pop),
    .result      (result),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // one input transaction; a gap of idle cycles may come first
  // push is assigned once per time step, so back-to-back bytes keep it high
  task automatic send_byte(input logic [7:0] b, input logic rs);
    int unsigned gap;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (bytes_sent[7]) gap = 0;  // steady stretches with no idling
    else if (roll < 70) gap = 0;
    else if (roll < 95) gap = $urandom_range(1, 3);
    else gap = $urandom_range(10, 40);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    item <= {b, rs};
    // full read right after the edge is the value the block sampled
    do @(posedge clk); while (full);
    bytes_sent++;
  endtask

  // header, optional extended length, optional key, then pay_cnt payload bytes
  task automatic build_frame(input logic [3:0] opc, input bit mk, input logic [63:0] len,
                             input len_form_t form, input logic [31:0] mkey,
                             input int unsigned pay_cnt);
    logic [6:0] len7;
    frame_bytes.delete();
    // fin and reserved bits are don't-care for the parser
    frame_bytes.push_back({4'($urandom_range(0, 15)), opc});
    case (form)
      LEN_16:  len7 = LEN_EXT16;
      LEN_64:  len7 = LEN_EXT64;
      default: len7 = len[6:0];
    endcase
    frame_bytes.push_back({mk, len7});
    if (form == LEN_16) begin
      frame_bytes.push_back(len[15:8]);
      frame_bytes.push_back(len[7:0]);
    end else if (form == LEN_64) begin
      for (int i = 7; i >= 0; i--) frame_bytes.push_back(len[8 * i +: 8]);
    end
    if (mk) for (int i = 3; i >= 0; i--) frame_bytes.push_back(mkey[8 * i +: 8]);
    for (int unsigned i = 0; i < pay_cnt; i++) frame_bytes.push_back(8'($urandom));
  endtask

  // restart rides on the first byte when asked
  task automatic send_frame(input bit rs_first, input int unsigned count);
    for (int unsigned i = 0; i < count; i++) send_byte(frame_bytes[i], rs_first && (i == 0));
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (outstanding != 0);
  endtask

  // receiver: random pop with short and long gaps, one long hold-off mid run
  initial begin
    int unsigned hold_left;
    int unsigned roll;
    bit          long_done;
    hold_left = 0;
    long_done = 1'b0;
    forever begin
      @(posedge clk);
      if (pop && !empty) results_taken++;
      if (hold_left > 0) begin
        pop <= 1'b0;
        hold_left--;
      end else if (!long_done && results_taken >= HOLD_AFTER) begin
        long_done = 1'b1;
        hold_left = LONG_HOLD;
        pop <= 1'b0;
      end else if (results_taken[8]) begin
        pop <= 1'b1;  // steady draining stretch
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 70) begin
          pop <= 1'b1;
        end else if (roll < 95) begin
          pop <= 1'b0;
          hold_left = $urandom_range(0, 3);
        end else begin
          pop <= 1'b0;
          hold_left = $urandom_range(10, 60);
        end
      end
    end
  end

  // watchdog on cycles with no transaction at all
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((push && !full) || (pop && !empty)) quiet = 0;
      else quiet++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  // stimulus and verdict
  initial begin
    logic [3:0]  opc;
    logic [63:0] len;
    logic [31:0] mkey;
    len_form_t   form;
    bit          mk;
    bit          need_restart;
    int unsigned roll;
    int unsigned pay_cnt;
    int unsigned count;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: empty text frame on the second header byte
    build_frame(4'h1, 1'b0, 64'd0, LEN_SHORT, 32'h0, 0);
    send_frame(1'b0, frame_bytes.size());
    // masked ping with an all-ones key
    build_frame(4'h9, 1'b1, 64'd2, LEN_SHORT, 32'hFFFF_FFFF, 2);
    send_frame(1'b0, frame_bytes.size());
    // non-minimal 16-bit length of zero, empty result on the last length byte
    build_frame(4'h2, 1'b0, 64'd0, LEN_16, 32'h0, 0);
    send_frame(1'b0, frame_bytes.size());
    // 64-bit length of all ones, unmasked, one payload byte then cut off
    build_frame(4'hF, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF, LEN_64, 32'h0, 0);
    frame_bytes.push_back(8'hFF);
    send_frame(1'b0, frame_bytes.size());
    // restart into a masked empty close, then a byte the closed stream drops
    build_frame(OP_CLOSE, 1'b1, 64'd0, LEN_SHORT, 32'h0, 0);
    send_frame(1'b1, frame_bytes.size());
    send_byte(8'h00, 1'b0);
    // restart into a one-byte close, closing rides on its payload byte
    build_frame(OP_CLOSE, 1'b0, 64'd1, LEN_SHORT, 32'h0, 1);
    send_frame(1'b1, frame_bytes.size());
    need_restart = 1'b1;

    // sender pauses until everything expected has come out
    push <= 1'b0;
    wait_drained();

    // random: mostly well-formed frames, some cut short, some noise
    while (bytes_sent < ITEM_TARGET) begin
      opc  = 4'($urandom_range(0, 15));
      if ($urandom_range(0, 99) < 8) opc = OP_CLOSE;
      mk   = $urandom_range(0, 1);
      mkey = $urandom;
      roll = $urandom_range(0, 99);
      if (roll < 70) begin
        form = LEN_SHORT;
        len = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 12) : $urandom_range(13, 125);
      end else if (roll < 90) begin
        form = LEN_16;
        roll = $urandom_range(0, 99);
        if (roll < 60) len = $urandom_range(0, 40);
        else if (roll < 90) len = $urandom_range(126, 300);
        else len = {48'd0, 16'($urandom)};
      end else begin
        form = LEN_64;
        roll = $urandom_range(0, 99);
        if (roll < 60) len = $urandom_range(0, 20);
        else if (roll < 80) len = $urandom_range(126, 200);
        else len = {$urandom, $urandom};
      end
      // huge lengths only get a few payload bytes before a restart
      pay_cnt = (len > 64'd400) ? $urandom_range(0, 10) : int'(len);
      build_frame(opc, mk, len, form, mkey, pay_cnt);
      count = frame_bytes.size();
      if ($urandom_range(0, 99) < 5) count = $urandom_range(1, count);
      if ($urandom_range(0, 99) < 3) need_restart = 1'b1;
      send_frame(need_restart, count);
      need_restart = (count < frame_bytes.size()) || (len > 64'(pay_cnt));
      if (!need_restart && opc == OP_CLOSE) begin
        // closed stream: a few bytes it should drop
        repeat ($urandom_range(0, 3)) send_byte(8'($urandom), 1'b0);
        need_restart = 1'b1;
      end
      if ($urandom_range(0, 99) < 4) begin
        // noise leaves the parser anywhere
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom), 1'b0);
        need_restart = 1'b1;
      end
    end

    push <= 1'b0;
    wait_drained();
    // allow for the block's queue and result register and any stray result
    repeat (10) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

### websocket_frame_deframer_unit.f
+incdir+hw/rtl
hw/rtl/wsd_pkg.sv
hw/rtl/wsd_front.sv
hw/rtl/wsd_queue.sv
hw/rtl/wsd_back.sv
hw/rtl/websocket_frame_deframer_unit.sv
tb/sv/deframer_checker.sv
tb/sv/tb_top.sv
